// ===== sv/dsbm_pkg.sv =====
// ----------------------------------------------------------------------------
// dsbm_pkg: shared types and constants of the delta-sigma modulator
// Word and register geometry, reset values, sequencer states and the
// control group that the sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package dsbm_pkg;

	localparam int MAX_WORDS       = 8;
	localparam int BITS_PER_WORD   = 32;
	localparam int STEP_SHIFT_BASE = 4;
	localparam int LEVEL_SHIFT     = 8;

	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 24;
	localparam int WORD_W   = 32;
	localparam int WPS_W    = 4;
	localparam int PREF_W   = 24;
	localparam int CFG_W    = 24;
	localparam int BIT_CNT_W  = $clog2(BITS_PER_WORD);
	localparam int WORD_CNT_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

	localparam logic [WPS_W-1:0]  WPS_RESET  = 4'd1;
	localparam logic [PREF_W-1:0] PREF_RESET = 24'd8388352;

	typedef enum logic [0:0] {
		REG_WORDS_PER_SAMPLE   = 1'b0,
		REG_POSITIVE_REFERENCE = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} seq_state_t;

	typedef struct packed {
		logic load;
		logic step_en;
	} dp_ctrl_t;

endpackage

// ===== sv/delta_sigma_bitstream_modulator.sv =====
// ----------------------------------------------------------------------------
// delta_sigma_bitstream_modulator: first-order pulse-density modulator
// Turns each signed 16-bit PCM sample into words_per_sample 32-bit words of
// pulse-density bits, MSB first, the last word of a sample flagged.
//
// Input channel: sample with in_valid/in_stall; an item is taken when
// in_valid is high and in_stall low. in_stall is high while a sample is
// being worked on.
// Output channel: bit_word and last_word with out_valid/out_stall; the
// receiver holds out_stall high to keep the current word.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (0 words_per_sample, 1 positive_reference); write only while idle.
// Timing: the shared accumulator adder makes one bit per cycle unless a
// stalled output register holds it back. A words_per_sample above 8
// counts as 8; zero emits no word.
// A stalled output register holds the last bit of the next word back.
// Reset: clears levels, accumulator and output valid; registers go to
// words_per_sample 1 and positive_reference 8388352.
// ----------------------------------------------------------------------------
module delta_sigma_bitstream_modulator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  dsbm_pkg::cfg_reg_t            cfg_index,
	input  logic [dsbm_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [dsbm_pkg::SAMPLE_W-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dsbm_pkg::WORD_W-1:0]   bit_word,
	output logic                          last_word
);
	import dsbm_pkg::*;

	logic [WPS_W-1:0]  wps_q;
	logic [PREF_W-1:0] pref_q;
	logic [WPS_W-1:0]  count;
	dp_ctrl_t          ctrl;
	logic [WORD_W-1:0] word_nxt;

	assign count = (wps_q > WPS_W'(MAX_WORDS)) ? WPS_W'(MAX_WORDS) : wps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wps_q  <= WPS_RESET;
			pref_q <= PREF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WORDS_PER_SAMPLE:   wps_q  <= cfg_data[WPS_W-1:0];
				REG_POSITIVE_REFERENCE: pref_q <= cfg_data[PREF_W-1:0];
				default: ;
			endcase
		end
	end

	dsbm_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.count     (count),
		.word_nxt  (word_nxt),
		.ctrl      (ctrl),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.bit_word  (bit_word),
		.last_word (last_word)
	);

	dsbm_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctrl               (ctrl),
		.sample             (sample),
		.count              (count),
		.positive_reference (pref_q),
		.word_nxt           (word_nxt)
	);

endmodule

// ===== sv/dsbm_dp.sv =====
// ----------------------------------------------------------------------------
// dsbm_dp: modulator datapath
// Holds previous level, reference, step, error accumulator and the bit
// shift register; one accumulator update and one bit per enabled cycle.
// ----------------------------------------------------------------------------
module dsbm_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dsbm_pkg::dp_ctrl_t             ctrl,
	input  logic [dsbm_pkg::SAMPLE_W-1:0]  sample,
	input  logic [dsbm_pkg::WPS_W-1:0]     count,
	input  logic [dsbm_pkg::PREF_W-1:0]    positive_reference,
	output logic [dsbm_pkg::WORD_W-1:0]    word_nxt
);
	import dsbm_pkg::*;

	logic [LEVEL_W-1:0]       prev_q;
	logic [WORD_W-1:0]        acc_q;
	logic [WORD_W-1:0]        ref_q;
	logic [WORD_W-1:0]        step_q;
	logic [WORD_W-1:0]        bits_q;
	logic [WORD_W-1:0]        level32;
	logic signed [WORD_W-1:0] diff32;
	logic [WPS_W-1:0]         shamt;
	logic [WORD_W-1:0]        step_nxt;
	logic [WORD_W-1:0]        pref32;
	logic [WORD_W-1:0]        addend;
	logic [WORD_W-1:0]        acc_nxt;

	assign level32  = {{(WORD_W-SAMPLE_W-LEVEL_SHIFT){sample[SAMPLE_W-1]}}, sample,
		{LEVEL_SHIFT{1'b0}}};
	assign diff32   = signed'(level32 - {{(WORD_W-LEVEL_W){prev_q[LEVEL_W-1]}}, prev_q});
	assign shamt    = WPS_W'(STEP_SHIFT_BASE) + count;
	assign step_nxt = WORD_W'(diff32 >>> shamt);

	assign pref32   = {{(WORD_W-PREF_W){1'b0}}, positive_reference};
	assign addend   = acc_q[WORD_W-1] ? pref32 : (~pref32 + WORD_W'(1));
	assign acc_nxt  = acc_q - ref_q + addend;
	assign word_nxt = {bits_q[WORD_W-2:0], acc_q[WORD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			acc_q  <= '0;
		end else begin
			if (ctrl.load) begin
				prev_q <= level32[LEVEL_W-1:0];
			end
			if (ctrl.step_en) begin
				acc_q <= acc_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			ref_q  <= level32;
			step_q <= step_nxt;
		end else if (ctrl.step_en) begin
			ref_q  <= ref_q + step_q;
			bits_q <= word_nxt;
		end
	end

endmodule

// ===== sv/dsbm_seq.sv =====
// ----------------------------------------------------------------------------
// dsbm_seq: bit and word sequencer with output register
// Counts bits and words of one item, steps the datapath and loads each
// finished word into the output register.
// ----------------------------------------------------------------------------
module dsbm_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dsbm_pkg::WPS_W-1:0]    count,
	input  logic [dsbm_pkg::WORD_W-1:0]   word_nxt,
	output dsbm_pkg::dp_ctrl_t            ctrl,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dsbm_pkg::WORD_W-1:0]   bit_word,
	output logic                          last_word
);
	import dsbm_pkg::*;

	seq_state_t            state_q;
	seq_state_t            state_nxt;
	logic [BIT_CNT_W-1:0]  bit_cnt_q;
	logic [WORD_CNT_W-1:0] word_cnt_q;
	logic [WPS_W-1:0]      count_q;
	logic                  out_valid_q;
	logic [WORD_W-1:0]     out_word_q;
	logic                  out_last_q;
	logic                  accept;
	logic                  can_load;
	logic                  bit_end;
	logic                  word_done;
	logic                  last;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign can_load  = !out_valid_q || !out_stall;
	assign bit_end   = (bit_cnt_q == BIT_CNT_W'(BITS_PER_WORD - 1));
	assign word_done = (state_q == ST_RUN) && bit_end && can_load;
	assign last      = ((WPS_W'(word_cnt_q) + WPS_W'(1)) == count_q);

	assign out_valid = out_valid_q;
	assign bit_word  = out_word_q;
	assign last_word = out_last_q;

	always_comb begin
		state_nxt    = state_q;
		ctrl.load    = 1'b0;
		ctrl.step_en = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.load = accept;
				if (accept && (count != '0)) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				ctrl.step_en = !bit_end || can_load;
				if (word_done && last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q   <= '0;
			word_cnt_q  <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				bit_cnt_q  <= '0;
				word_cnt_q <= '0;
				count_q    <= count;
			end else if (ctrl.step_en) begin
				bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
				if (word_done && !last) begin
					word_cnt_q <= word_cnt_q + WORD_CNT_W'(1);
				end
			end
			if (word_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (word_done) begin
			out_word_q <= word_nxt;
			out_last_q <= last;
		end
	end

endmodule
